[sv/piexu_pkg.sv]
`timescale 1ns / 1ps
package piexu_pkg;
	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_ADDC = 6'd1, OP_ADDE = 6'd2, OP_ADDI = 6'd3, OP_ADDIC = 6'd4,
		OP_ADDIC_RC = 6'd5, OP_ADDIS = 6'd6, OP_ADDME = 6'd7, OP_ADDZE = 6'd8,
		OP_AND = 6'd9, OP_ANDC = 6'd10, OP_ANDI = 6'd11, OP_ANDIS = 6'd12,
		OP_CNTLZW = 6'd13, OP_DIVW = 6'd14, OP_DIVWU = 6'd15, OP_EQV = 6'd16,
		OP_EXTSB = 6'd17, OP_EXTSH = 6'd18, OP_MULHW = 6'd19, OP_MULHWU = 6'd20,
		OP_MULLI = 6'd21, OP_MULLW = 6'd22, OP_NAND = 6'd23, OP_NEG = 6'd24,
		OP_NOR = 6'd25, OP_OR = 6'd26, OP_ORC = 6'd27, OP_ORI = 6'd28, OP_ORIS = 6'd29,
		OP_RLWIMI = 6'd30, OP_RLWINM = 6'd31, OP_RLWNM = 6'd32, OP_SRW = 6'd33,
		OP_SLW = 6'd34, OP_SRAW = 6'd35, OP_SRAWI = 6'd36, OP_SUBF = 6'd37,
		OP_SUBFC = 6'd38, OP_SUBFE = 6'd39, OP_SUBFIC = 6'd40, OP_SUBFME = 6'd41,
		OP_SUBFZE = 6'd42, OP_XOR = 6'd43, OP_XORI = 6'd44, OP_XORIS = 6'd45
	} op_t;

	typedef struct packed {
		logic [5:0]  action;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [31:0] insert_target;
		logic [15:0] imm16;
		logic [4:0]  shift_imm;
		logic [4:0]  mask_begin;
		logic [4:0]  mask_end;
		logic        record_bit;
		logic        overflow_enable;
		logic        ra_field_zero;
	} item_t;

	typedef struct packed {
		logic [31:0] result;
		logic [3:0]  cr0_field;
		logic        cr0_write;
		logic        carry_out;
		logic        overflow_out;
		logic        summary_overflow_out;
	} res_t;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} bst_t;
endpackage

[sv/piexu_if.sv]
`timescale 1ns / 1ps
interface piexu_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/ppc_integer_execute_unit_top.sv]
`timescale 1ns / 1ps
// Path from transfer in to result valid: queue, operand register, execute;
// divw/divwu add 32 radix-2 divider steps.
// The back end works one item at a time, the front queue holds two more.
// Reset (arst_n low, asynchronous) clears CA, OV, SO, the queue and all valids.
module ppc_integer_execute_unit_top (
	input logic clk,
	input logic arst_n,
	piexu_if.sink   in_ch,
	piexu_if.source out_ch
);
	piexu_pkg::item_t q_item;
	logic q_valid, q_ready;
	piexu_pkg::res_t res;

	piexu_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_item(piexu_pkg::item_t'(in_ch.data)), .in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.q_item(q_item), .q_valid(q_valid), .q_ready(q_ready)
	);

	piexu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_item(q_item), .q_valid(q_valid), .q_ready(q_ready),
		.out_res(res), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);

	assign out_ch.data = res;
endmodule

[sv/piexu_front.sv]
`timescale 1ns / 1ps
// Input stage and two-entry queue towards the execute part.
module piexu_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  piexu_pkg::item_t      in_item,
	input  logic                  in_valid,
	output logic                  in_ready,
	output piexu_pkg::item_t      q_item,
	output logic                  q_valid,
	input  logic                  q_ready
);
	piexu_pkg::item_t mem_q [piexu_pkg::QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'(piexu_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(piexu_pkg::QDEPTH)) else $error("queue overfull");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif
endmodule

[sv/piexu_back.sv]
`timescale 1ns / 1ps
// Execute part: combinational ops, registered multiply, radix-2 divider.
module piexu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  piexu_pkg::item_t      q_item,
	input  logic                  q_valid,
	output logic                  q_ready,
	output piexu_pkg::res_t       out_res,
	output logic                  out_valid,
	input  logic                  out_ready
);
	piexu_pkg::bst_t st_q, st_d;
	piexu_pkg::item_t it_q;
	logic ca_q, ov_q, so_q;
	piexu_pkg::res_t res_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;

	// combinational results for the held item
	logic [31:0] a, b, simm, x, y, r, m, rot, rsa;
	logic [32:0] sum;
	logic        cin, is_add, keep_ca, keep_ov, rec, ca_n, ov_n, ov_upd, ca_upd;
	logic [5:0]  sam;
	logic [4:0]  rn;
	logic [31:0] fb, te;
	logic [5:0]  lz;
	logic        prod_ov, dbad, is_mul, is_div;
	logic [32:0] dtry;
	logic        so_n;
	logic [3:0]  cr;
	logic [31:0] ua, ub;

	always_comb begin
		a = it_q.operand_a;
		b = it_q.operand_b;
		simm = {{16{it_q.imm16[15]}}, it_q.imm16};
		x = 32'd0; y = 32'd0; cin = 1'b0;
		is_add = 1'b0; keep_ca = 1'b0; keep_ov = 1'b0; rec = 1'b0;
		r = 32'd0; ca_upd = 1'b0; ca_n = ca_q; ov_upd = 1'b0; ov_n = 1'b0;
		rn = (it_q.action == piexu_pkg::OP_RLWNM) ? b[4:0] : it_q.shift_imm;
		rot = (a << rn) | (a >> (6'd32 - {1'b0, rn}));
		fb = 32'hFFFFFFFF >> it_q.mask_begin;
		te = 32'hFFFFFFFF << (5'd31 - it_q.mask_end);
		m = (it_q.mask_begin <= it_q.mask_end) ? (fb & te) : (fb | te);
		sam = (it_q.action == piexu_pkg::OP_SRAWI) ? {1'b0, it_q.shift_imm} : b[5:0];
		rsa = sam[5] ? {32{a[31]}} : 32'($signed(a) >>> sam[4:0]);
		lz = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (a[i]) lz = 6'(31 - i);
		end
		prod_ov = (prod_q[63:32] != {32{prod_q[31]}});
		dbad = (it_q.action == piexu_pkg::OP_DIVW) ?
			((b == 32'd0) || (a == 32'h80000000 && b == 32'hFFFFFFFF)) : (b == 32'd0);
		unique case (it_q.action)
			piexu_pkg::OP_ADD: begin is_add = 1; x = a; y = b; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_ADDC: begin is_add = 1; x = a; y = b; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_ADDE: begin is_add = 1; x = a; y = b; cin = ca_q; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_ADDI: begin is_add = 1; x = it_q.ra_field_zero ? 32'd0 : a; y = simm; end
			piexu_pkg::OP_ADDIC: begin is_add = 1; x = a; y = simm; keep_ca = 1; end
			piexu_pkg::OP_ADDIC_RC: begin is_add = 1; x = a; y = simm; keep_ca = 1; rec = 1; end
			piexu_pkg::OP_ADDIS: begin is_add = 1; x = it_q.ra_field_zero ? 32'd0 : a; y = {it_q.imm16, 16'd0}; end
			piexu_pkg::OP_ADDME: begin is_add = 1; x = a; y = 32'hFFFFFFFF; cin = ca_q; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_ADDZE: begin is_add = 1; x = a; cin = ca_q; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_AND: begin r = a & b; rec = it_q.record_bit; end
			piexu_pkg::OP_ANDC: begin r = a & ~b; rec = it_q.record_bit; end
			piexu_pkg::OP_ANDI: begin r = a & {16'd0, it_q.imm16}; rec = 1; end
			piexu_pkg::OP_ANDIS: begin r = a & {it_q.imm16, 16'd0}; rec = 1; end
			piexu_pkg::OP_CNTLZW: begin r = {26'd0, lz}; rec = it_q.record_bit; end
			piexu_pkg::OP_DIVW, piexu_pkg::OP_DIVWU: begin
				if (dbad) r = (it_q.action == piexu_pkg::OP_DIVW && a[31]) ? 32'hFFFFFFFF : 32'd0;
				else r = dneg_q ? 32'd0 - quo_q : quo_q;
				ov_upd = it_q.overflow_enable; ov_n = dbad; rec = it_q.record_bit;
			end
			piexu_pkg::OP_EQV: begin r = ~(a ^ b); rec = it_q.record_bit; end
			piexu_pkg::OP_EXTSB: begin r = {{24{a[7]}}, a[7:0]}; rec = it_q.record_bit; end
			piexu_pkg::OP_EXTSH: begin r = {{16{a[15]}}, a[15:0]}; rec = it_q.record_bit; end
			piexu_pkg::OP_MULHW, piexu_pkg::OP_MULHWU: begin r = prod_q[63:32]; rec = it_q.record_bit; end
			piexu_pkg::OP_MULLI: r = prod_q[31:0];
			piexu_pkg::OP_MULLW: begin
				r = prod_q[31:0]; ov_upd = it_q.overflow_enable; ov_n = prod_ov;
				rec = it_q.record_bit;
			end
			piexu_pkg::OP_NAND: begin r = ~(a & b); rec = it_q.record_bit; end
			piexu_pkg::OP_NEG: begin
				r = 32'd0 - a; ov_upd = it_q.overflow_enable; ov_n = (a == 32'h80000000);
				rec = it_q.record_bit;
			end
			piexu_pkg::OP_NOR: begin r = ~(a | b); rec = it_q.record_bit; end
			piexu_pkg::OP_OR: begin r = a | b; rec = it_q.record_bit; end
			piexu_pkg::OP_ORC: begin r = a | ~b; rec = it_q.record_bit; end
			piexu_pkg::OP_ORI: r = a | {16'd0, it_q.imm16};
			piexu_pkg::OP_ORIS: r = a | {it_q.imm16, 16'd0};
			piexu_pkg::OP_RLWIMI: begin r = (rot & m) | (it_q.insert_target & ~m); rec = it_q.record_bit; end
			piexu_pkg::OP_RLWINM, piexu_pkg::OP_RLWNM: begin r = rot & m; rec = it_q.record_bit; end
			piexu_pkg::OP_SRW: begin r = b[5] ? 32'd0 : a >> b[4:0]; rec = it_q.record_bit; end
			piexu_pkg::OP_SLW: begin r = b[5] ? 32'd0 : a << b[4:0]; rec = it_q.record_bit; end
			piexu_pkg::OP_SRAW, piexu_pkg::OP_SRAWI: begin
				r = rsa; ca_upd = 1'b1; rec = it_q.record_bit;
				ca_n = a[31] && (sam[5] || ((a & ~(32'hFFFFFFFF << sam[4:0])) != 32'd0));
			end
			piexu_pkg::OP_SUBF: begin is_add = 1; x = ~a; y = b; cin = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_SUBFC: begin is_add = 1; x = ~a; y = b; cin = 1; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_SUBFE: begin is_add = 1; x = ~a; y = b; cin = ca_q; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_SUBFIC: begin is_add = 1; x = ~a; y = simm; cin = 1; keep_ca = 1; end
			piexu_pkg::OP_SUBFME: begin is_add = 1; x = ~a; y = 32'hFFFFFFFF; cin = ca_q; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_SUBFZE: begin is_add = 1; x = ~a; cin = ca_q; keep_ca = 1; keep_ov = 1; rec = it_q.record_bit; end
			piexu_pkg::OP_XOR: begin r = a ^ b; rec = it_q.record_bit; end
			piexu_pkg::OP_XORI: r = a ^ {16'd0, it_q.imm16};
			piexu_pkg::OP_XORIS: r = a ^ {it_q.imm16, 16'd0};
			default: ;
		endcase
		sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
		if (is_add) begin
			r = sum[31:0];
			if (keep_ca) begin ca_upd = 1'b1; ca_n = sum[32]; end
			if (keep_ov) begin
				ov_upd = it_q.overflow_enable;
				ov_n = (x[31] ^ r[31]) & (y[31] ^ r[31]);
			end
		end
		so_n = so_q | (ov_upd & ov_n);
		cr = r[31] ? 4'b1000 : ((r != 32'd0) ? 4'b0100 : 4'b0010);
		cr[0] = so_n;
		is_mul = (it_q.action == piexu_pkg::OP_MULHW) || (it_q.action == piexu_pkg::OP_MULHWU)
			|| (it_q.action == piexu_pkg::OP_MULLI) || (it_q.action == piexu_pkg::OP_MULLW);
		is_div = (it_q.action == piexu_pkg::OP_DIVW) || (it_q.action == piexu_pkg::OP_DIVWU);
	end

	// operand magnitudes taken from the queue head for the divider
	always_comb begin
		if (q_item.action == piexu_pkg::OP_DIVW) begin
			ua = q_item.operand_a[31] ? 32'd0 - q_item.operand_a : q_item.operand_a;
			ub = q_item.operand_b[31] ? 32'd0 - q_item.operand_b : q_item.operand_b;
		end else begin
			ua = q_item.operand_a;
			ub = q_item.operand_b;
		end
	end

	assign dtry = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			piexu_pkg::ST_IDLE: if (q_valid) st_d = piexu_pkg::ST_MUL;
			piexu_pkg::ST_MUL: st_d = is_div ? piexu_pkg::ST_DIV : piexu_pkg::ST_DONE;
			piexu_pkg::ST_DIV: if (dcnt_q == 6'd31) st_d = piexu_pkg::ST_DONE;
			piexu_pkg::ST_DONE: if (!out_valid || out_ready) st_d = piexu_pkg::ST_IDLE;
			default: st_d = piexu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (st_q == piexu_pkg::ST_IDLE);
	end

	logic done_fire;
	assign done_fire = (st_q == piexu_pkg::ST_DONE) && (!out_valid || out_ready);
	assign out_res = res_q;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			it_q   <= q_item;
			quo_q  <= ua;
			dvs_q  <= ub;
			rem_q  <= 32'd0;
			dneg_q <= (q_item.action == piexu_pkg::OP_DIVW) &&
				(q_item.operand_a[31] ^ q_item.operand_b[31]);
		end
		if (st_q == piexu_pkg::ST_MUL && is_mul) begin
			if (it_q.action == piexu_pkg::OP_MULHWU)
				prod_q <= {32'd0, a} * {32'd0, b};
			else if (it_q.action == piexu_pkg::OP_MULLI)
				prod_q <= 64'($signed(a) * $signed(simm));
			else
				prod_q <= 64'($signed(a) * $signed(b));
		end
		if (st_q == piexu_pkg::ST_DIV) begin
			if (!dtry[32]) begin
				rem_q <= dtry[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (done_fire) begin
			res_q.result               <= r;
			res_q.cr0_field            <= rec ? cr : 4'd0;
			res_q.cr0_write            <= rec;
			res_q.carry_out            <= ca_upd ? ca_n : ca_q;
			res_q.overflow_out         <= ov_upd ? ov_n : ov_q;
			res_q.summary_overflow_out <= so_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= piexu_pkg::ST_IDLE;
			ca_q      <= 1'b0;
			ov_q      <= 1'b0;
			so_q      <= 1'b0;
			dcnt_q    <= 6'd0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == piexu_pkg::ST_MUL) dcnt_q <= 6'd0;
			else if (st_q == piexu_pkg::ST_DIV) dcnt_q <= dcnt_q + 6'd1;
			if (done_fire) begin
				out_valid <= 1'b1;
				if (ca_upd) ca_q <= ca_n;
				if (ov_upd) ov_q <= ov_n;
				so_q <= so_n;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_so_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(so_q) |-> so_q) else $error("SO cleared");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == piexu_pkg::ST_DIV |-> dcnt_q < 6'd32) else $error("divider overrun");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> st_q == piexu_pkg::ST_MUL) else $error("bad start");
`endif
endmodule

[tb/sv/ppc_integer_execute_unit_top_test.sv]
`timescale 1ns / 1ps
module ppc_integer_execute_unit_top_test;
	import piexu_pkg::*;

	logic clk;
	logic arst_n;

	piexu_if #(.W($bits(item_t))) in_ch ();
	piexu_if #(.W($bits(res_t)))  out_ch ();

	ppc_integer_execute_unit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	localparam int STALL_LIMIT = 4000;
	localparam logic [31:0] SIGN32 = 32'h8000_0000;
	localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

	// architectural XER bits as the predictor sees them
	logic xer_ca, xer_ov, xer_so;
	res_t pending_results[$];
	int mismatches;
	int idle_cycles;
	bit timed_out;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] sext16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] field_mask(logic [4:0] mb, logic [4:0] me);
		logic [31:0] from_begin, to_end;
		from_begin = ALL32 >> mb;
		to_end = ALL32 << (5'd31 - me);
		return (mb <= me) ? (from_begin & to_end) : (from_begin | to_end);
	endfunction

	function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
		return (n == 0) ? v : ((v << n) | (v >> (6'd32 - n)));
	endfunction

	function automatic void update_ov(logic v);
		xer_ov = v;
		if (v)
			xer_so = 1'b1;
	endfunction

	function automatic logic [31:0] sra_with_carry(logic [31:0] v, logic [5:0] n);
		logic [31:0] r;
		if (n >= 32) begin
			xer_ca = v[31];
			return v[31] ? ALL32 : 32'd0;
		end
		if (n == 0) begin
			xer_ca = 1'b0;
			return v;
		end
		r = $unsigned($signed(v) >>> n);
		xer_ca = v[31] && ((v & ((32'd1 << n) - 1)) != 0);
		return r;
	endfunction

	function automatic res_t execute_insn(item_t it);
		res_t r;
		logic [31:0] a, b, x, y, q, ua, ub, m;
		logic [32:0] s;
		logic [63:0] p;
		logic cin, is_add, sets_ca, sets_ov, rec, bad;
		a = it.operand_a;
		b = it.operand_b;
		x = 0; y = 0; cin = 0; is_add = 0; sets_ca = 0; sets_ov = 0;
		rec = 0;
		r = '0;
		case (it.action)
			OP_ADD: begin is_add = 1; x = a; y = b; sets_ov = it.overflow_enable;
				rec = it.record_bit; end
			OP_ADDC: begin is_add = 1; x = a; y = b; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_ADDE: begin is_add = 1; x = a; y = b; cin = xer_ca; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_ADDI: begin is_add = 1; x = it.ra_field_zero ? 32'd0 : a;
				y = sext16(it.imm16); end
			OP_ADDIC: begin is_add = 1; x = a; y = sext16(it.imm16); sets_ca = 1; end
			OP_ADDIC_RC: begin is_add = 1; x = a; y = sext16(it.imm16); sets_ca = 1;
				rec = 1; end
			OP_ADDIS: begin is_add = 1; x = it.ra_field_zero ? 32'd0 : a;
				y = {it.imm16, 16'd0}; end
			OP_ADDME: begin is_add = 1; x = a; y = ALL32; cin = xer_ca; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_ADDZE: begin is_add = 1; x = a; cin = xer_ca; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_AND: begin r.result = a & b; rec = it.record_bit; end
			OP_ANDC: begin r.result = a & ~b; rec = it.record_bit; end
			OP_ANDI: begin r.result = a & {16'd0, it.imm16}; rec = 1; end
			OP_ANDIS: begin r.result = a & {it.imm16, 16'd0}; rec = 1; end
			OP_CNTLZW: begin
				r.result = 32;
				for (int i = 31; i >= 0; i--)
					if (a[i] && r.result == 32)
						r.result = 31 - i;
				rec = it.record_bit;
			end
			OP_DIVW: begin
				bad = (b == 0) || (a == SIGN32 && b == ALL32);
				if (bad) begin
					r.result = a[31] ? ALL32 : 32'd0;
				end else begin
					ua = a[31] ? -a : a;
					ub = b[31] ? -b : b;
					q = ua / ub;
					r.result = (a[31] ^ b[31]) ? -q : q;
				end
				if (it.overflow_enable)
					update_ov(bad);
				rec = it.record_bit;
			end
			OP_DIVWU: begin
				r.result = (b == 0) ? 32'd0 : a / b;
				if (it.overflow_enable)
					update_ov(b == 0);
				rec = it.record_bit;
			end
			OP_EQV: begin r.result = ~(a ^ b); rec = it.record_bit; end
			OP_EXTSB: begin r.result = {{24{a[7]}}, a[7:0]}; rec = it.record_bit; end
			OP_EXTSH: begin r.result = sext16(a[15:0]); rec = it.record_bit; end
			OP_MULHW: begin
				p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				r.result = p[63:32]; rec = it.record_bit;
			end
			OP_MULHWU: begin p = {32'd0, a} * {32'd0, b}; r.result = p[63:32];
				rec = it.record_bit; end
			OP_MULLI: begin
				p = $signed({{32{a[31]}}, a}) * $signed({{48{it.imm16[15]}}, it.imm16});
				r.result = p[31:0];
			end
			OP_MULLW: begin
				p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				r.result = p[31:0];
				if (it.overflow_enable)
					update_ov(p[63:31] != {33{p[31]}});
				rec = it.record_bit;
			end
			OP_NAND: begin r.result = ~(a & b); rec = it.record_bit; end
			OP_NEG: begin
				r.result = -a;
				if (it.overflow_enable)
					update_ov(a == SIGN32);
				rec = it.record_bit;
			end
			OP_NOR: begin r.result = ~(a | b); rec = it.record_bit; end
			OP_OR: begin r.result = a | b; rec = it.record_bit; end
			OP_ORC: begin r.result = a | ~b; rec = it.record_bit; end
			OP_ORI: r.result = a | {16'd0, it.imm16};
			OP_ORIS: r.result = a | {it.imm16, 16'd0};
			OP_RLWIMI: begin
				m = field_mask(it.mask_begin, it.mask_end);
				r.result = (rotl(a, it.shift_imm) & m) | (it.insert_target & ~m);
				rec = it.record_bit;
			end
			OP_RLWINM: begin
				r.result = rotl(a, it.shift_imm) & field_mask(it.mask_begin, it.mask_end);
				rec = it.record_bit;
			end
			OP_RLWNM: begin
				r.result = rotl(a, b[4:0]) & field_mask(it.mask_begin, it.mask_end);
				rec = it.record_bit;
			end
			OP_SRW: begin r.result = b[5] ? 32'd0 : a >> b[4:0]; rec = it.record_bit; end
			OP_SLW: begin r.result = b[5] ? 32'd0 : a << b[4:0]; rec = it.record_bit; end
			OP_SRAW: begin r.result = sra_with_carry(a, b[5:0]); rec = it.record_bit; end
			OP_SRAWI: begin r.result = sra_with_carry(a, {1'b0, it.shift_imm});
				rec = it.record_bit; end
			OP_SUBF: begin is_add = 1; x = ~a; y = b; cin = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_SUBFC: begin is_add = 1; x = ~a; y = b; cin = 1; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_SUBFE: begin is_add = 1; x = ~a; y = b; cin = xer_ca; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_SUBFIC: begin is_add = 1; x = ~a; y = sext16(it.imm16); cin = 1;
				sets_ca = 1; end
			OP_SUBFME: begin is_add = 1; x = ~a; y = ALL32; cin = xer_ca; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_SUBFZE: begin is_add = 1; x = ~a; cin = xer_ca; sets_ca = 1;
				sets_ov = it.overflow_enable; rec = it.record_bit; end
			OP_XOR: begin r.result = a ^ b; rec = it.record_bit; end
			OP_XORI: r.result = a ^ {16'd0, it.imm16};
			OP_XORIS: r.result = a ^ {it.imm16, 16'd0};
			default: ;
		endcase
		if (is_add) begin
			s = {1'b0, x} + {1'b0, y} + {32'd0, cin};
			r.result = s[31:0];
			if (sets_ca)
				xer_ca = s[32];
			if (sets_ov)
				update_ov((x[31] ^ s[31]) & (y[31] ^ s[31]));
		end
		if (rec) begin
			r.cr0_field = r.result[31] ? 4'b1000 : (r.result != 0 ? 4'b0100 : 4'b0010);
			r.cr0_field[0] = xer_so;
		end
		r.cr0_write = rec;
		r.carry_out = xer_ca;
		r.overflow_out = xer_ov;
		r.summary_overflow_out = xer_so;
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return ALL32;
			2: return SIGN32;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t random_insn(bit any_code);
		item_t it;
		it.action = any_code ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 45));
		it.operand_a = rand_operand();
		it.operand_b = rand_operand();
		it.insert_target = $urandom;
		it.imm16 = 16'($urandom);
		it.shift_imm = 5'($urandom);
		it.mask_begin = 5'($urandom);
		it.mask_end = 5'($urandom);
		it.record_bit = 1'($urandom);
		it.overflow_enable = 1'($urandom);
		it.ra_field_zero = 1'($urandom);
		return it;
	endfunction

	// valid stays high across back-to-back transfers; dropped only for idle gaps
	task automatic send_insn(item_t it);
		int idle;
		idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
		if (idle > 0) begin
			in_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(execute_insn(it));
	endtask

	// result sink: random stall per transfer, then compare
	initial begin
		int stall;
		res_t got, want;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got = out_ch.data;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer out: %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: res %h/%h cr %h/%h w %b/%b ca %b/%b ov %b/%b so %b/%b",
							want.result, got.result, want.cr0_field, got.cr0_field,
							want.cr0_write, got.cr0_write, want.carry_out, got.carry_out,
							want.overflow_out, got.overflow_out,
							want.summary_overflow_out, got.summary_overflow_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Verification failed");
			$finish;
		end
	end

	task automatic test_edges();
		item_t it;
		op_t op;
		// every operation once on extreme operands
		op = op.first();
		do begin
			it = '0;
			it.action = op;
			it.operand_a = SIGN32;
			it.operand_b = ALL32;
			it.imm16 = 16'hFFFF;
			it.shift_imm = 5'd31;
			it.mask_begin = 5'd31;
			it.mask_end = 5'd0;
			it.insert_target = 32'hA5A5_5A5A;
			it.record_bit = 1'b1;
			it.overflow_enable = 1'b1;
			it.ra_field_zero = 1'b1;
			send_insn(it);
			op = op.next();
		end while (op != op.first());
	endtask

	task automatic test_special_cases();
		item_t it;
		it = '0;
		it.overflow_enable = 1'b1;
		it.record_bit = 1'b1;
		it.action = OP_DIVW; it.operand_a = 32'h8000_0001; it.operand_b = 0; send_insn(it);
		it.action = OP_DIVWU; it.operand_a = 32'd7; it.operand_b = 0; send_insn(it);
		it.action = OP_DIVW; it.overflow_enable = 1'b0; send_insn(it);
		it.action = OP_SRAW; it.operand_a = 32'h8000_0000; it.operand_b = 32'd40; send_insn(it);
		it.action = OP_SRAW; it.operand_a = 32'h8000_0001; it.operand_b = 32'd1; send_insn(it);
		it.action = OP_SRW; it.operand_a = ALL32; it.operand_b = 32'd32; send_insn(it);
		it.action = OP_SLW; it.operand_b = 32'd63; send_insn(it);
		it.action = OP_RLWNM; it.operand_b = 32'h3F; it.mask_begin = 5'd4;
		it.mask_end = 5'd27; send_insn(it);
		it.action = 6'd63; send_insn(it);
		it.action = OP_ADDI; it.ra_field_zero = 1'b0; it.imm16 = 16'h8000; send_insn(it);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_insn(random_insn($urandom_range(0, 19) == 0));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		xer_ca = 0; xer_ov = 0; xer_so = 0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_special_cases();
		test_random(1700);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
